>>> rtl/core/center_crop_nearest_scaler_core_assert.svh
// Assertion macros used by the scaler core's job queue.
`ifndef CENTER_CROP_NEAREST_SCALER_CORE_ASSERT_SVH
`define CENTER_CROP_NEAREST_SCALER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CCNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CCNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ccns_pkg.sv
// Shared constants and types of the center-crop nearest scaler core.
package ccns_pkg;

  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int DST_W    = 8;
  localparam int TSIZE_W  = 9;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TARGET_SIZE   = 2'd2;

  localparam logic [COORD_W-1:0] RESET_SOURCE_WIDTH  = 16'd1;
  localparam logic [COORD_W-1:0] RESET_SOURCE_HEIGHT = 16'd1;
  localparam logic [TSIZE_W-1:0] RESET_TARGET_SIZE   = 9'd56;

  localparam int QUEUE_DEPTH = 2;

  typedef logic [COLOR_W-1:0] color_t;

  // One classified source pixel: the first target index and the number of
  // kept target indices on each axis, plus the overflow flag and its color.
  typedef struct packed {
    logic [DST_W-1:0] lo_x;
    logic [DST_W-1:0] lo_y;
    logic [CNT_W-1:0] cnt_x;
    logic [CNT_W-1:0] cnt_y;
    logic             over;
    color_t           red;
    color_t           green;
    color_t           blue;
  } ccns_job_t;

endpackage

>>> rtl/core/center_crop_nearest_scaler_core.sv
// Top level of the center-crop nearest-neighbor square scaler core.
// The front part takes no new input beat until its bit-serial bound search for the last one is
// done and its job, if any, has gone into the queue; the back part loads a job, then walks its writes.
// The first result beat of a pixel leaves the back part's output register; later beats of the
// same pixel follow one per cycle while out_ready is high.
// Reset (rst, synchronous, active high) empties the queue; registers go to 1, 1 and 56.
module center_crop_nearest_scaler_core #(
  parameter int MAX_TARGET = 256,
  parameter int MAX_REPEAT = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ccns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccns_pkg::COORD_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ccns_pkg::COORD_W-1:0]   src_x,
  input  logic [ccns_pkg::COORD_W-1:0]   src_y,
  input  ccns_pkg::color_t               in_red,
  input  ccns_pkg::color_t               in_green,
  input  ccns_pkg::color_t               in_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ccns_pkg::DST_W-1:0]     dst_x,
  output logic [ccns_pkg::DST_W-1:0]     dst_y,
  output ccns_pkg::color_t               out_red,
  output ccns_pkg::color_t               out_green,
  output ccns_pkg::color_t               out_blue,
  output logic                           last_write,
  output logic                           repeat_overflow
);
  import ccns_pkg::*;

  // Configuration registers. Writes are taken whenever reset is low; an index
  // beyond the register list is dropped. The block is expected to be idle
  // during writes.
  logic [COORD_W-1:0] source_width;
  logic [COORD_W-1:0] source_height;
  logic [TSIZE_W-1:0] target_size;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RESET_SOURCE_WIDTH;
      source_height <= RESET_SOURCE_HEIGHT;
      target_size   <= RESET_TARGET_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_SOURCE_WIDTH:  source_width  <= cfg_data;
        CFG_IDX_SOURCE_HEIGHT: source_height <= cfg_data;
        CFG_IDX_TARGET_SIZE:   target_size   <= cfg_data[TSIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front part classifies each pixel into a job: the first sampling
  // target index and the kept copy count on each axis. Pixels that no
  // target samples never reach the queue.
  ccns_job_t front_job;
  ccns_job_t head_job;
  logic      q_push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  ccns_front #(
    .MAX_TARGET(MAX_TARGET),
    .MAX_REPEAT(MAX_REPEAT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_width(source_width),
    .cfg_height(source_height),
    .cfg_size(target_size),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .src_x(src_x),
    .src_y(src_y),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .job(front_job),
    .push(q_push),
    .full(q_full)
  );

  // The queue lets the front start on the next pixel while the back part
  // is still streaming out the copies of an upscaled one.
  ccns_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_job(front_job),
    .push(q_push),
    .full(q_full),
    .rd_job(head_job),
    .pop(q_pop),
    .empty(q_empty)
  );

  // The back part walks each job row-major and presents one target write
  // per output beat from its output register.
  ccns_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head_job),
    .empty(q_empty),
    .pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dst_x(dst_x),
    .dst_y(dst_y),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .last_write(last_write),
    .repeat_overflow(repeat_overflow)
  );

endmodule

>>> rtl/core/ccns_bound_search.sv
// One lane of the bit-serial search for an axis sampling bound.
module ccns_bound_search #(
  parameter int SW = 9
) (
  input  logic          clk,
  input  logic          start,
  input  logic          run,
  input  logic [SW-1:0] probe,
  input  logic [SW-1:0] size_eff,
  input  logic [15:0]   side,
  input  logic [SW+17:0] rhs,
  output logic [SW-1:0] bound
);

  // bound counts the target indices i below size_eff with
  // (2i+1)*side < rhs; one result bit is settled per cycle, MSB first.
  logic [SW-1:0]  cand;
  logic [SW:0]    odd;
  logic [SW+16:0] prod;
  logic           take;

  always_comb begin
    cand = bound | probe;
    odd  = {cand, 1'b0} - {{SW{1'b0}}, 1'b1};
    prod = (SW+17)'(odd) * (SW+17)'(side);
    take = (cand <= size_eff) && ({1'b0, prod} < rhs);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bound <= '0;
    end else if (run && take) begin
      bound <= cand;
    end
  end

endmodule

>>> rtl/core/ccns_front.sv
// Front part: accepts source pixels and works out their target index ranges.
module ccns_front #(
  parameter int MAX_TARGET = 256,
  parameter int MAX_REPEAT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ccns_pkg::COORD_W-1:0] cfg_width,
  input  logic [ccns_pkg::COORD_W-1:0] cfg_height,
  input  logic [ccns_pkg::TSIZE_W-1:0] cfg_size,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ccns_pkg::COORD_W-1:0] src_x,
  input  logic [ccns_pkg::COORD_W-1:0] src_y,
  input  ccns_pkg::color_t            in_red,
  input  ccns_pkg::color_t            in_green,
  input  ccns_pkg::color_t            in_blue,
  output ccns_pkg::ccns_job_t         job,
  output logic                        push,
  input  logic                        full
);
  import ccns_pkg::*;

  localparam int SW = $clog2(MAX_TARGET + 1);
  localparam int PW = SW + 18;

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_GEOM   = 3'd1;
  localparam logic [2:0] F_OFFS   = 3'd2;
  localparam logic [2:0] F_MUL    = 3'd3;
  localparam logic [2:0] F_SEARCH = 3'd4;
  localparam logic [2:0] F_PUSH   = 3'd5;

  logic [2:0]         state, state_next;
  logic [COORD_W-1:0] px, py;
  color_t             red, green, blue;
  logic [COORD_W-1:0] side, off_x, off_y, dx, dy;
  logic               in_x, in_y;
  logic [SW-1:0]      size_eff;
  logic [PW-1:0]      rhs_lo_x, rhs_hi_x, rhs_lo_y, rhs_hi_y;
  logic [SW-1:0]      probe;
  logic [SW-1:0]      lo_x, hi_x, lo_y, hi_y;

  logic [COORD_W-1:0] w_eff, h_eff, side_c;
  logic [31:0]        size_c;
  logic [SW-1:0]      raw_x, raw_y;
  logic [CNT_W-1:0]   kept_x, kept_y;
  logic               over, has_hits;
  logic               start, run;

  assign in_ready = (state == F_IDLE) && !rst;
  assign start    = (state == F_MUL);
  assign run      = (state == F_SEARCH);

  always_comb begin
    w_eff  = (cfg_width == '0) ? COORD_W'(1) : cfg_width;
    h_eff  = (cfg_height == '0) ? COORD_W'(1) : cfg_height;
    side_c = (w_eff < h_eff) ? w_eff : h_eff;
    size_c = (cfg_size == '0) ? 32'd1 : 32'(cfg_size);
    if (size_c > 32'(MAX_TARGET)) begin
      size_c = 32'(MAX_TARGET);
    end
  end

  // Range sizes; a pixel left of or above the crop has no hits.
  always_comb begin
    raw_x  = in_x ? (hi_x - lo_x) : '0;
    raw_y  = in_y ? (hi_y - lo_y) : '0;
    kept_x = (32'(raw_x) > 32'(MAX_REPEAT)) ? CNT_W'(MAX_REPEAT) : CNT_W'(raw_x);
    kept_y = (32'(raw_y) > 32'(MAX_REPEAT)) ? CNT_W'(MAX_REPEAT) : CNT_W'(raw_y);
    over   = (32'(raw_x) > 32'(MAX_REPEAT)) || (32'(raw_y) > 32'(MAX_REPEAT));
    has_hits = (kept_x != '0) && (kept_y != '0);
  end

  always_comb begin
    job.lo_x  = lo_x[DST_W-1:0];
    job.lo_y  = lo_y[DST_W-1:0];
    job.cnt_x = kept_x;
    job.cnt_y = kept_y;
    job.over  = over;
    job.red   = red;
    job.green = green;
    job.blue  = blue;
    push      = (state == F_PUSH) && has_hits && !full;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (in_valid) state_next = F_GEOM;
      F_GEOM:   state_next = F_OFFS;
      F_OFFS:   state_next = F_MUL;
      F_MUL:    state_next = F_SEARCH;
      F_SEARCH: if (probe[0]) state_next = F_PUSH;
      F_PUSH:   if (!has_hits || !full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        px    <= src_x;
        py    <= src_y;
        red   <= in_red;
        green <= in_green;
        blue  <= in_blue;
      end
      F_GEOM: begin
        side     <= side_c;
        off_x    <= (w_eff - side_c) >> 1;
        off_y    <= (h_eff - side_c) >> 1;
        size_eff <= SW'(size_c);
      end
      F_OFFS: begin
        dx   <= px - off_x;
        dy   <= py - off_y;
        in_x <= (px >= off_x);
        in_y <= (py >= off_y);
      end
      F_MUL: begin
        rhs_lo_x <= PW'({size_eff, 1'b0}) * PW'(dx);
        rhs_hi_x <= PW'({size_eff, 1'b0}) * PW'({1'b0, dx} + 17'd1);
        rhs_lo_y <= PW'({size_eff, 1'b0}) * PW'(dy);
        rhs_hi_y <= PW'({size_eff, 1'b0}) * PW'({1'b0, dy} + 17'd1);
        probe    <= {1'b1, {(SW-1){1'b0}}};
      end
      F_SEARCH: begin
        probe <= probe >> 1;
      end
      default: begin
      end
    endcase
  end

  ccns_bound_search #(.SW(SW)) u_lo_x (
    .clk(clk), .start(start), .run(run), .probe(probe), .size_eff(size_eff),
    .side(side), .rhs(rhs_lo_x), .bound(lo_x)
  );

  ccns_bound_search #(.SW(SW)) u_hi_x (
    .clk(clk), .start(start), .run(run), .probe(probe), .size_eff(size_eff),
    .side(side), .rhs(rhs_hi_x), .bound(hi_x)
  );

  ccns_bound_search #(.SW(SW)) u_lo_y (
    .clk(clk), .start(start), .run(run), .probe(probe), .size_eff(size_eff),
    .side(side), .rhs(rhs_lo_y), .bound(lo_y)
  );

  ccns_bound_search #(.SW(SW)) u_hi_y (
    .clk(clk), .start(start), .run(run), .probe(probe), .size_eff(size_eff),
    .side(side), .rhs(rhs_hi_y), .bound(hi_y)
  );

endmodule

>>> rtl/core/ccns_queue.sv
// Short job queue between the front and back parts.
`include "center_crop_nearest_scaler_core_assert.svh"

module ccns_queue (
  input  logic                clk,
  input  logic                rst,
  input  ccns_pkg::ccns_job_t wr_job,
  input  logic                push,
  output logic                full,
  output ccns_pkg::ccns_job_t rd_job,
  input  logic                pop,
  output logic                empty
);
  import ccns_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  ccns_job_t     slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full   = (count == CW'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `CCNS_ASSERT_NOW(a_no_push_full, push, !full, "job pushed into a full queue")
  `CCNS_ASSERT_NOW(a_no_pop_empty, pop, !empty, "job popped from an empty queue")
  `CCNS_ASSERT_NEXT(a_fill_grows, push && !pop, count == $past(count) + CW'(1), "queue fill count did not grow on push")

endmodule

>>> rtl/core/ccns_back.sv
// Back part: expands one job into its target writes through an output register.
module ccns_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ccns_pkg::ccns_job_t           head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ccns_pkg::DST_W-1:0]    dst_x,
  output logic [ccns_pkg::DST_W-1:0]    dst_y,
  output ccns_pkg::color_t              out_red,
  output ccns_pkg::color_t              out_green,
  output ccns_pkg::color_t              out_blue,
  output logic                          last_write,
  output logic                          repeat_overflow
);
  import ccns_pkg::*;

  ccns_job_t        job;
  logic             busy;
  logic [CNT_W-1:0] row, col;
  logic             adv, col_last, row_last;

  assign adv      = !out_valid || out_ready;
  assign pop      = !busy && !empty;
  assign col_last = (col == job.cnt_x - CNT_W'(1));
  assign row_last = (row == job.cnt_y - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && adv && col_last && row_last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
      row <= '0;
      col <= '0;
    end else if (busy && adv) begin
      dst_x           <= job.lo_x + DST_W'(col);
      dst_y           <= job.lo_y + DST_W'(row);
      out_red         <= job.red;
      out_green       <= job.green;
      out_blue        <= job.blue;
      last_write      <= col_last && row_last;
      repeat_overflow <= job.over;
      if (col_last) begin
        col <= '0;
        row <= row + CNT_W'(1);
      end else begin
        col <= col + CNT_W'(1);
      end
    end
  end

endmodule

>>> verif/tb_center_crop_nearest_scaler_core.sv
// Self-checking testbench for the center-crop nearest-neighbor square scaler core.
`timescale 1ns / 100ps

module tb_center_crop_nearest_scaler_core;
  import ccns_pkg::*;

  localparam int MAX_TARGET = 256;
  localparam int MAX_REPEAT = 8;

  // Index 3 is not a register. A write to it must leave all three alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // A pixel that maps to no target gives no sign that it has left the pipe, so
  // the quiet wait before a register write outlasts the front part's work on a
  // pixel and the path to its first write, with margin.
  localparam int DRAIN_CYCLES   = 40;
  // The limit lies far above the longest correct gap between two beats on any
  // channel, which includes the drain pause and random stalls on both sides.
  localparam int WATCHDOG_LIMIT = 5000;

  // One source pixel as it is offered on the input channel.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    color_t             red;
    color_t             green;
    color_t             blue;
  } src_pixel_t;

  // One register write as it is offered on the configuration channel.
  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;
  } reg_write_t;

  // One target write as it should leave the output channel.
  typedef struct packed {
    logic [DST_W-1:0] dst_x;
    logic [DST_W-1:0] dst_y;
    color_t           red;
    color_t           green;
    color_t           blue;
    logic             last;
    logic             over;
  } target_write_t;

  // Effective crop geometry after the zero and range clamps.
  typedef struct packed {
    logic [31:0] side;
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] size;
  } crop_t;

  // Target indices on one axis that sample a given source coordinate.
  typedef struct packed {
    logic [CNT_W-1:0]                   count;
    logic                               over;
    logic [MAX_REPEAT-1:0][DST_W-1:0]   index;
  } axis_taps_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data  = '0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [COORD_W-1:0] src_x    = '0;
  logic [COORD_W-1:0] src_y    = '0;
  color_t             in_red   = '0;
  color_t             in_green = '0;
  color_t             in_blue  = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DST_W-1:0] dst_x;
  logic [DST_W-1:0] dst_y;
  color_t           out_red;
  color_t           out_green;
  color_t           out_blue;
  logic             last_write;
  logic             repeat_overflow;

  center_crop_nearest_scaler_core #(
    .MAX_TARGET(MAX_TARGET),
    .MAX_REPEAT(MAX_REPEAT)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .src_x          (src_x),
    .src_y          (src_y),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dst_x          (dst_x),
    .dst_y          (dst_y),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .last_write     (last_write),
    .repeat_overflow(repeat_overflow)
  );

  always #5 clk = ~clk;

  // Work still to be offered, filled by the sequence below.
  src_pixel_t    pixel_backlog[$];
  reg_write_t    reg_backlog[$];
  // Target writes predicted for accepted pixels, oldest first.
  target_write_t due_writes[$];

  // Register copies kept by the predictor, updated on each register beat.
  logic [COORD_W-1:0] mdl_width;
  logic [COORD_W-1:0] mdl_height;
  logic [TSIZE_W-1:0] mdl_tsize;

  // Geometry that the sequence is currently aiming its pixels at.
  crop_t stim_crop;
  // While set, neither side of the block inserts idle cycles.
  logic  no_idle = 1'b0;

  int mismatches      = 0;
  int idle_cycles     = 0;
  int pixels_accepted = 0;
  int writes_checked  = 0;
  int overflow_writes = 0;
  int reg_beats       = 0;
  int geometries      = 1;

  target_write_t want;

  // Applies the zero-means-one and range clamps and finds the centered
  // square crop of the source image.
  function automatic crop_t crop_of(input logic [COORD_W-1:0] w_reg,
                                    input logic [COORD_W-1:0] h_reg,
                                    input logic [TSIZE_W-1:0] ts_reg);
    crop_t       c;
    logic [31:0] w;
    logic [31:0] h;
    w = (w_reg == 0) ? 32'd1 : 32'(w_reg);
    h = (h_reg == 0) ? 32'd1 : 32'(h_reg);
    c.size = (ts_reg == 0) ? 32'd1 : 32'(ts_reg);
    if (c.size > MAX_TARGET) c.size = MAX_TARGET;
    c.side = (w < h) ? w : h;
    c.ox = (w - c.side) / 2;
    c.oy = (h - c.side) / 2;
    return c;
  endfunction

  // Target index i samples offset + floor((2i+1)*side / (2*size)). Only the
  // lowest MAX_REPEAT matching indices are kept; any more set the over flag.
  function automatic axis_taps_t find_taps(input logic [31:0] pos, off, side, size);
    axis_taps_t      t;
    longint unsigned m;
    int              i;
    t = '0;
    for (i = 0; i < size; i++) begin
      m = ((2 * longint'(i) + 1) * longint'(side)) / (2 * longint'(size));
      if (longint'(off) + m == longint'(pos)) begin
        if (t.count < MAX_REPEAT) begin
          t.index[t.count] = i[DST_W-1:0];
          t.count = t.count + 1'b1;
        end else begin
          t.over = 1'b1;
        end
      end
    end
    return t;
  endfunction

  // Queues every target write that one source pixel causes, row-major, with
  // the final one marked last and the overflow flag shared by all of them.
  task automatic map_pixel_to_target(input src_pixel_t p);
    crop_t         c;
    axis_taps_t    tx;
    axis_taps_t    ty;
    target_write_t wr;
    int            a;
    int            b;
    c  = crop_of(mdl_width, mdl_height, mdl_tsize);
    tx = find_taps(32'(p.x), c.ox, c.side, c.size);
    ty = find_taps(32'(p.y), c.oy, c.side, c.size);
    for (a = 0; a < ty.count; a++) begin
      for (b = 0; b < tx.count; b++) begin
        wr.dst_x = tx.index[b];
        wr.dst_y = ty.index[a];
        wr.red   = p.red;
        wr.green = p.green;
        wr.blue  = p.blue;
        wr.last  = (a == ty.count - 1) && (b == tx.count - 1);
        wr.over  = tx.over | ty.over;
        due_writes.push_back(wr);
      end
    end
  endtask

  // Most pixels land exactly on a sampled coordinate, some land anywhere in
  // the crop, and the rest are fully random and mostly miss the crop.
  function automatic src_pixel_t make_pixel(input crop_t c);
    src_pixel_t  p;
    int unsigned pick;
    int unsigned ix;
    int unsigned iy;
    p.red   = color_t'($urandom);
    p.green = color_t'($urandom);
    p.blue  = color_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      ix  = $urandom_range(0, c.size - 1);
      iy  = $urandom_range(0, c.size - 1);
      p.x = COORD_W'(c.ox + ((2 * ix + 1) * c.side) / (2 * c.size));
      p.y = COORD_W'(c.oy + ((2 * iy + 1) * c.side) / (2 * c.size));
    end else if (pick < 85) begin
      p.x = COORD_W'(c.ox + $urandom_range(0, c.side - 1));
      p.y = COORD_W'(c.oy + $urandom_range(0, c.side - 1));
    end else begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
    end
    return p;
  endfunction

  // A 15 percent chance of idling in each cycle unless idling is switched off.
  function automatic logic may_go();
    return no_idle || ($urandom_range(0, 99) >= 15);
  endfunction

  task automatic check_field(input string field, input logic [7:0] exp_val, act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Driver: offers the next register write and the next pixel. A valid that
  // is up stays up with a steady payload until its beat is taken; a new
  // beat may follow directly in the cycle after a handshake.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      in_valid  <= 1'b0;
    end else begin
      if (!cfg_valid || cfg_ready) begin
        if (reg_backlog.size() > 0 && may_go()) begin
          cfg_valid <= 1'b1;
          cfg_index <= reg_backlog[0].index;
          cfg_data  <= reg_backlog[0].data;
          void'(reg_backlog.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end
      if (!in_valid || in_ready) begin
        if (pixel_backlog.size() > 0 && may_go()) begin
          in_valid <= 1'b1;
          src_x    <= pixel_backlog[0].x;
          src_y    <= pixel_backlog[0].y;
          in_red   <= pixel_backlog[0].red;
          in_green <= pixel_backlog[0].green;
          in_blue  <= pixel_backlog[0].blue;
          void'(pixel_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiving side stalls at random, like a frame buffer that is busy.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= may_go();
    end
  end

  // Monitor: tracks register beats, predicts writes for each pixel beat,
  // checks each write beat against the oldest prediction and keeps the
  // watchdog that ends a hung run.
  always @(posedge clk) begin
    if (rst) begin
      mdl_width   = RESET_SOURCE_WIDTH;
      mdl_height  = RESET_SOURCE_HEIGHT;
      mdl_tsize   = RESET_TARGET_SIZE;
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_SOURCE_WIDTH: begin
            mdl_width = cfg_data;
          end
          CFG_IDX_SOURCE_HEIGHT: begin
            mdl_height = cfg_data;
          end
          CFG_IDX_TARGET_SIZE: begin
            mdl_tsize = cfg_data[TSIZE_W-1:0];
          end
          default: begin
          end
        endcase
        reg_beats++;
      end
      if (in_valid && in_ready) begin
        map_pixel_to_target({src_x, src_y, in_red, in_green, in_blue});
        pixels_accepted++;
      end
      if (out_valid && out_ready) begin
        if (due_writes.size() == 0) begin
          $display("%0t: write beat with none predicted, actual x=%0d y=%0d rgb=%0d/%0d/%0d",
                   $time, dst_x, dst_y, out_red, out_green, out_blue);
          mismatches++;
        end else begin
          want = due_writes.pop_front();
          check_field("dst_x", want.dst_x, dst_x);
          check_field("dst_y", want.dst_y, dst_y);
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("last_write", 8'(want.last), 8'(last_write));
          check_field("repeat_overflow", 8'(want.over), 8'(repeat_overflow));
          if (want.over) overflow_writes++;
        end
        writes_checked++;
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat on any channel for %0d cycles, %0d writes still due",
                 $time, idle_cycles, due_writes.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Sequence helpers. They run on the falling edge, away from the edge at
  // which the driver and the monitor act.
  task automatic wait_results();
    while (pixel_backlog.size() > 0 || in_valid || due_writes.size() > 0) begin
      @(negedge clk);
    end
  endtask

  // Before a register write: all writes back, then a quiet spell for any
  // pixel still in the pipe that maps to nothing.
  task automatic wait_drain();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic wait_regs();
    while (reg_backlog.size() > 0 || cfg_valid) begin
      @(negedge clk);
    end
  endtask

  task automatic set_geometry(input logic [COORD_W-1:0] w, h, ts);
    wait_drain();
    reg_backlog.push_back({CFG_IDX_SOURCE_WIDTH, w});
    reg_backlog.push_back({CFG_IDX_SOURCE_HEIGHT, h});
    reg_backlog.push_back({CFG_IDX_TARGET_SIZE, ts});
    wait_regs();
    stim_crop = crop_of(w, h, ts[TSIZE_W-1:0]);
    geometries++;
  endtask

  task automatic push_pixel(input logic [COORD_W-1:0] x, y, input color_t r, g, b);
    pixel_backlog.push_back({x, y, r, g, b});
  endtask

  task automatic fill_random(input int n);
    repeat (n) pixel_backlog.push_back(make_pixel(stim_crop));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry: a 1x1 source blown up to 56x56, so pixel (0,0) is
    // sampled 56 times per axis and hits the repeat limit on both.
    stim_crop = crop_of(RESET_SOURCE_WIDTH, RESET_SOURCE_HEIGHT, RESET_TARGET_SIZE);
    push_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
    push_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'd1, 16'd0, 8'h11, 8'h22, 8'h33);
    push_pixel(16'd0, 16'd1, 8'h44, 8'h55, 8'h66);
    push_pixel(16'hFFFF, 16'hFFFF, 8'hAA, 8'h55, 8'h0F);
    fill_random(10);

    // All-zero registers fall back to a 1x1 source and a 1x1 target.
    set_geometry(16'd0, 16'd0, 16'd0);
    push_pixel(16'd0, 16'd0, 8'h12, 8'h34, 8'h56);
    push_pixel(16'd0, 16'd1, 8'h01, 8'h02, 8'h03);
    push_pixel(16'd1, 16'd1, 8'h80, 8'h40, 8'h20);
    fill_random(10);

    // Landscape downscale: crop starts at column 80. Crop corners, the
    // columns just outside it and the first sampled pixel.
    set_geometry(16'd640, 16'd480, 16'd56);
    push_pixel(16'd80, 16'd0, 8'h01, 8'hFE, 8'h7F);
    push_pixel(16'd559, 16'd479, 8'hFE, 8'h01, 8'h80);
    push_pixel(16'd79, 16'd240, 8'h10, 8'h20, 8'h30);
    push_pixel(16'd560, 16'd240, 8'h40, 8'h50, 8'h60);
    push_pixel(16'd84, 16'd4, 8'hC3, 8'h3C, 8'h99);
    fill_random(30);
    // Hold back the rest until every write of the first half is out.
    wait_results();
    fill_random(30);

    set_geometry(16'd480, 16'd640, 16'd100);
    fill_random(50);

    // Strong upscale: each source pixel covers 16 target indices per axis.
    set_geometry(16'd16, 16'd16, 16'd256);
    fill_random(40);

    // Full coordinate range, run with no idling on either side.
    set_geometry(16'hFFFF, 16'hFFFF, 16'd256);
    no_idle = 1'b1;
    fill_random(40);
    wait_results();
    no_idle = 1'b0;

    // Square 3x3 crop in the middle of a wide, short source, with a target
    // size register of 511 that is clamped to the maximum. The write to the
    // unused index must change nothing.
    set_geometry(16'hFFFF, 16'd3, 16'hFFFF);
    reg_backlog.push_back({CFG_IDX_UNUSED, 16'h0001});
    wait_regs();
    push_pixel(16'd32766, 16'd0, 8'h5A, 8'hA5, 8'hFF);
    push_pixel(16'd32768, 16'd2, 8'h00, 8'hFF, 8'h00);
    push_pixel(16'd32765, 16'd1, 8'h0F, 8'hF0, 8'h0F);
    push_pixel(16'd32769, 16'd1, 8'hF0, 8'h0F, 8'hF0);
    fill_random(30);

    // Target size just above the maximum.
    set_geometry(16'd100, 16'd37, 16'd257);
    fill_random(30);

    // A few random geometries, the last one with a single-pixel target.
    for (int j = 0; j < 4; j++) begin
      set_geometry(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                   (j == 3) ? 16'd1 : 16'($urandom_range(1, MAX_TARGET)));
      fill_random(30);
    end

    wait_drain();
    $display("Covered %0d pixel beats over %0d geometries and %0d register beats;",
             pixels_accepted, geometries, reg_beats);
    $display("checked %0d write beats, %0d of them flagged as repeat overflow.",
             writes_checked, overflow_writes);
    if (mismatches == 0 && due_writes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ccns_pkg.sv
rtl/core/ccns_bound_search.sv
rtl/core/ccns_front.sv
rtl/core/ccns_queue.sv
rtl/core/ccns_back.sv
rtl/core/center_crop_nearest_scaler_core.sv
verif/tb_center_crop_nearest_scaler_core.sv
